### rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants for the character class skip scanner: opcodes,
// parse phases, control states and the structs passed between modules.
// ----------------------------------------------------------------------------
package ccs_pkg;

   // table size and field widths
   localparam int MAX_RANGES = 64;
   localparam int CP_W       = 21;
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);
   localparam int SPAN_W     = 31;
   localparam int MOVED_W    = 32;

   // special characters of the set spec
   localparam logic [CP_W-1:0] CH_CARET  = CP_W'('h5E);
   localparam logic [CP_W-1:0] CH_DASH   = CP_W'('h2D);
   localparam logic [CP_W-1:0] CH_BSLASH = CP_W'('h5C);

   // request opcodes
   typedef enum logic [1:0] {
      OP_BEGIN_SET  = 2'd0,
      OP_SET_ELEM   = 2'd1,
      OP_BEGIN_SCAN = 2'd2,
      OP_SCAN_CP    = 2'd3
   } op_type;

   // set spec parse phases
   typedef enum logic [2:0] {
      PH_START,
      PH_ITEM,
      PH_FROM_ESC,
      PH_AFTER_FROM,
      PH_DASH,
      PH_TO_ESC,
      PH_DONE
   } phase_type;

   // top level control states
   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_EVAL,
      CTRL_RESP
   } ctrl_state_type;

   // range pushed into the head of the cell chain
   typedef struct packed {
      logic            en;
      logic [CP_W-1:0] low;
      logic [CP_W-1:0] high;
   } commit_type;

   // set table status
   typedef struct packed {
      logic [CNT_W-1:0] range_count;
      logic             negated;
      logic             overflow;
   } set_status_type;

endpackage

### rtl/char_class_skip_scanner_core.sv
// ----------------------------------------------------------------------------
// char_class_skip_scanner_core
// Character set matcher with skip scanner. Set specs build a chain of range
// cells; scan codepoints compare against all cells at once and advance the
// signed move count until a non-member or the span limit.
// ----------------------------------------------------------------------------
// A start transfer passes request capture, the registered cell compare and
// the scan update before the rsp_valid strobe; the next start waits for idle.
// busy is high in the evaluate and response states; results cannot be stalled.
// Reset: synchronous, clears the set table count, flags, parse phase and
// scan state (scan stopped); range cells are not cleared and need no sweep.
module char_class_skip_scanner_core
   import ccs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_operation,
   input  logic [CP_W-1:0]           req_codepoint,
   input  logic                      req_is_last,
   input  logic                      req_scan_backward,
   input  logic [SPAN_W-1:0]         req_span,
   output logic                      rsp_valid,
   output logic                      rsp_is_member,
   output logic                      rsp_stopped,
   output logic signed [MOVED_W-1:0] rsp_moved,
   output logic [CNT_W-1:0]          rsp_range_count,
   output logic                      rsp_set_negated,
   output logic                      rsp_set_overflow
);

   ctrl_state_type state_ff, state_in;

   // captured request
   op_type             op_ff;
   logic [CP_W-1:0]    cp_ff;
   logic               last_ff;
   logic               back_ff;
   logic [SPAN_W-1:0]  span_ff;

   // scan state
   logic                      done_ff, done_in;
   logic                      going_back_ff, going_back_in;
   logic [SPAN_W-1:0]         span_left_ff, span_left_in;
   logic signed [MOVED_W-1:0] moved_ff, moved_in;
   logic                      member_ff, member_in;
   logic                      valid_ff, valid_in;

   logic           accept;
   logic           resp_cycle;
   logic           any_hit;
   logic           member;
   commit_type     commit;
   set_status_type status;

   logic [CP_W-1:0]       chain_low  [MAX_RANGES+1];
   logic [CP_W-1:0]       chain_high [MAX_RANGES+1];
   logic [MAX_RANGES-1:0] hits;

   assign accept = start && !busy;

   // request capture on transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_operation);
         cp_ff   <= req_codepoint;
         last_ff <= req_is_last;
         back_ff <= req_scan_backward;
         span_ff <= req_span;
      end
   end

   // control state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and handshake outputs
   always_comb begin
      state_in   = state_ff;
      busy       = 1'b1;
      resp_cycle = 1'b0;
      unique case (state_ff)
         CTRL_IDLE: begin
            busy = 1'b0;
            if (start) begin
               state_in = CTRL_EVAL;
            end
         end
         CTRL_EVAL: begin
            state_in = CTRL_RESP;
         end
         CTRL_RESP: begin
            resp_cycle = 1'b1;
            state_in   = CTRL_IDLE;
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   // set spec parser
   ccs_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .clear_en  (resp_cycle && op_ff == OP_BEGIN_SET),
      .elem_en   (resp_cycle && op_ff == OP_SET_ELEM),
      .elem_cp   (cp_ff),
      .elem_last (last_ff),
      .commit    (commit),
      .status    (status)
   );

   // chain of range cells, new ranges enter at the head
   assign chain_low[0]  = commit.low;
   assign chain_high[0] = commit.high;

   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      ccs_cell u_cell (
         .clock      (clock),
         .shift_en   (commit.en),
         .shift_low  (chain_low[i]),
         .shift_high (chain_high[i]),
         .active     (status.range_count > CNT_W'(i)),
         .test_cp    (cp_ff),
         .hold_low   (chain_low[i+1]),
         .hold_high  (chain_high[i+1]),
         .hit        (hits[i])
      );
   end

   assign any_hit = |hits;
   assign member  = any_hit ^ status.negated;

   // scan update
   always_comb begin
      done_in       = done_ff;
      going_back_in = going_back_ff;
      span_left_in  = span_left_ff;
      moved_in      = moved_ff;
      member_in     = member_ff;
      valid_in      = resp_cycle;
      if (resp_cycle) begin
         member_in = 1'b0;
         case (op_ff)
            OP_BEGIN_SCAN: begin
               going_back_in = back_ff;
               span_left_in  = span_ff;
               moved_in      = '0;
               done_in       = (span_ff == '0);
            end
            OP_SCAN_CP: begin
               if (!done_ff) begin
                  if (member) begin
                     member_in    = 1'b1;
                     span_left_in = span_left_ff - SPAN_W'(1);
                     moved_in     = going_back_ff ? moved_ff - MOVED_W'(1)
                                                  : moved_ff + MOVED_W'(1);
                     done_in      = (span_left_ff == SPAN_W'(1));
                  end else begin
                     done_in = 1'b1;
                  end
               end
            end
            default: begin
               member_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff       <= 1'b1;
         going_back_ff <= 1'b0;
         span_left_ff  <= '0;
         moved_ff      <= '0;
         member_ff     <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         done_ff       <= done_in;
         going_back_ff <= going_back_in;
         span_left_ff  <= span_left_in;
         moved_ff      <= moved_in;
         member_ff     <= member_in;
         valid_ff      <= valid_in;
      end
   end

   // result ports
   assign rsp_valid        = valid_ff;
   assign rsp_is_member    = member_ff;
   assign rsp_stopped      = done_ff;
   assign rsp_moved        = moved_ff;
   assign rsp_range_count  = status.range_count;
   assign rsp_set_negated  = status.negated;
   assign rsp_set_overflow = status.overflow;

endmodule

### rtl/ccs_cell.sv
// ----------------------------------------------------------------------------
// ccs_cell
// One range cell of the set table. Holds an inclusive range, passes it on to
// the next cell when a new range is pushed in, and registers a hit flag for
// the codepoint under test.
// ----------------------------------------------------------------------------
module ccs_cell
   import ccs_pkg::*;
(
   input  logic            clock,
   input  logic            shift_en,
   input  logic [CP_W-1:0] shift_low,
   input  logic [CP_W-1:0] shift_high,
   input  logic            active,
   input  logic [CP_W-1:0] test_cp,
   output logic [CP_W-1:0] hold_low,
   output logic [CP_W-1:0] hold_high,
   output logic            hit
);

   logic [CP_W-1:0] low_ff;
   logic [CP_W-1:0] high_ff;
   logic            hit_ff;
   logic            hit_in;

   // range compare, only for cells holding a committed range
   assign hit_in = active && (test_cp >= low_ff) && (test_cp <= high_ff);

   // range storage shifts toward the tail on each push
   always_ff @(posedge clock) begin
      if (shift_en) begin
         low_ff  <= shift_low;
         high_ff <= shift_high;
      end
      hit_ff <= hit_in;
   end

   assign hold_low  = low_ff;
   assign hold_high = high_ff;
   assign hit       = hit_ff;

endmodule

### rtl/ccs_parser.sv
// ----------------------------------------------------------------------------
// ccs_parser
// Set spec parser. Walks the caret, dash and backslash rules one element at
// a time, keeps the range count, negation and overflow flags, and feeds new
// ranges into the cell chain. An element may close two ranges; the second
// one is pushed in the following cycle.
// ----------------------------------------------------------------------------
module ccs_parser
   import ccs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            clear_en,
   input  logic            elem_en,
   input  logic [CP_W-1:0] elem_cp,
   input  logic            elem_last,
   output commit_type      commit,
   output set_status_type  status
);

   phase_type        phase_ff, phase_in;
   logic [CP_W-1:0]  pend_ff, pend_in;
   logic             neg_ff, neg_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic             defer_en_ff, defer_en_in;
   logic [CP_W-1:0]  defer_cp_ff;

   // first and second range closed by this element
   logic             ca_en;
   logic [CP_W-1:0]  ca_low;
   logic [CP_W-1:0]  ca_high;
   logic             cb_en;
   logic             a_ok;
   logic             b_ok;
   logic [CNT_W-1:0] used_a;
   logic             is_bs;
   logic             is_dash;

   assign is_bs   = (elem_cp == CH_BSLASH) && !elem_last;
   assign is_dash = (elem_cp == CH_DASH) && !elem_last;

   // phase machine and range count
   always_comb begin
      phase_in = phase_ff;
      pend_in  = pend_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      used_in  = used_ff;
      ca_en    = 1'b0;
      ca_low   = elem_cp;
      ca_high  = elem_cp;
      cb_en    = 1'b0;
      a_ok     = 1'b0;
      b_ok     = 1'b0;
      used_a   = used_ff;
      if (clear_en) begin
         phase_in = PH_START;
         pend_in  = '0;
         neg_in   = 1'b0;
         ovf_in   = 1'b0;
         used_in  = '0;
      end else if (elem_en) begin
         unique case (phase_ff) inside
            PH_START, PH_ITEM: begin
               if (phase_ff == PH_START && elem_cp == CH_CARET) begin
                  neg_in   = 1'b1;
                  phase_in = elem_last ? PH_DONE : PH_ITEM;
               end else if (is_bs) begin
                  phase_in = PH_FROM_ESC;
               end else if (elem_last) begin
                  ca_en    = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  pend_in  = elem_cp;
                  phase_in = PH_AFTER_FROM;
               end
            end
            PH_FROM_ESC: begin
               if (elem_last) begin
                  ca_en    = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  pend_in  = elem_cp;
                  phase_in = PH_AFTER_FROM;
               end
            end
            PH_AFTER_FROM: begin
               if (is_dash) begin
                  phase_in = PH_DASH;
               end else begin
                  // pending single character closes first
                  ca_en   = 1'b1;
                  ca_low  = pend_ff;
                  ca_high = pend_ff;
                  if (is_bs) begin
                     phase_in = PH_FROM_ESC;
                  end else if (elem_last) begin
                     cb_en    = 1'b1;
                     phase_in = PH_DONE;
                  end else begin
                     pend_in  = elem_cp;
                     phase_in = PH_AFTER_FROM;
                  end
               end
            end
            PH_DASH: begin
               if (is_bs) begin
                  phase_in = PH_TO_ESC;
               end else begin
                  ca_en    = 1'b1;
                  ca_low   = pend_ff;
                  phase_in = elem_last ? PH_DONE : PH_ITEM;
               end
            end
            PH_TO_ESC: begin
               ca_en    = 1'b1;
               ca_low   = pend_ff;
               phase_in = elem_last ? PH_DONE : PH_ITEM;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase

         // table room check for up to two ranges
         a_ok    = ca_en && (used_ff < CNT_W'(MAX_RANGES));
         used_a  = used_ff + CNT_W'(a_ok);
         b_ok    = cb_en && (used_a < CNT_W'(MAX_RANGES));
         used_in = used_a + CNT_W'(b_ok);
         if ((ca_en && !a_ok) || (cb_en && !b_ok)) begin
            ovf_in = 1'b1;
         end
      end
   end

   assign defer_en_in = b_ok;

   // parser control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         pend_ff     <= '0;
         neg_ff      <= 1'b0;
         ovf_ff      <= 1'b0;
         used_ff     <= '0;
         defer_en_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pend_ff     <= pend_in;
         neg_ff      <= neg_in;
         ovf_ff      <= ovf_in;
         used_ff     <= used_in;
         defer_en_ff <= defer_en_in;
      end
   end

   // second range is held in a register and pushed in the following cycle
   always_ff @(posedge clock) begin
      if (b_ok) begin
         defer_cp_ff <= elem_cp;
      end
   end

   // push into the chain head
   always_comb begin
      commit.en   = a_ok || defer_en_ff;
      commit.low  = defer_en_ff ? defer_cp_ff : ca_low;
      commit.high = defer_en_ff ? defer_cp_ff : ca_high;
   end

   assign status.range_count = used_ff;
   assign status.negated     = neg_ff;
   assign status.overflow    = ovf_ff;

endmodule
